### hdl/pslt_pkg.sv
// ----------------------------------------------------------------------------
// Packet sequence loss tracker package
// Shared types and constants for the loss tracker and its serial ratio unit.
// ----------------------------------------------------------------------------
package pslt_pkg;

  // Default sizes handed to the top level.
  localparam int CHANNELS_DEFAULT     = 4;
  localparam int COUNTER_BITS_DEFAULT = 32;

  // Fixed field widths.
  localparam int PAIR_BITS    = 16;
  localparam int SEQ_BITS     = 8;
  localparam int QUOT_BITS    = 15;
  localparam int OUT_CNT_BITS = 32;
  localparam int REPORT_BITS  = 5;

  // Full scale of the loss figure: 100 percent in Q8.
  localparam logic [QUOT_BITS-1:0] PERCENT_SCALE = 15'd25600;

  // Command codes.
  localparam logic CMD_ACCOUNT = 1'b0;
  localparam logic CMD_RESET   = 1'b1;

  // One incoming transaction.
  typedef struct packed {
    logic                command;
    logic [1:0]          channel;
    logic [7:0]          system_id;
    logic [7:0]          component_id;
    logic [SEQ_BITS-1:0] sequence_req;
  } item_t;

  // One outgoing transaction.
  typedef struct packed {
    logic [7:0]              lost_in_gap;
    logic [OUT_CNT_BITS-1:0] received_total;
    logic [OUT_CNT_BITS-1:0] lost_total;
    logic [QUOT_BITS-1:0]    loss_percent_q8;
    logic                    report_due;
  } result_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Status returned by the ratio unit.
  typedef struct packed {
    logic busy;
    logic done;
  } ratio_stat_t;

endpackage

### hdl/pslt_ratio.sv
// ----------------------------------------------------------------------------
// Serial scaled ratio unit
// Computes floor(25600 * num / den) exactly, full scale for num >= den, one
// modular step per cycle, walking the scale bits out of a shift register.
// ----------------------------------------------------------------------------
module pslt_ratio #(
  parameter int SUM_W = pslt_pkg::COUNTER_BITS_DEFAULT + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [SUM_W-1:0]                 num,
  input  logic [SUM_W-1:0]                 den,
  output logic [pslt_pkg::QUOT_BITS-1:0]   quotient,
  output pslt_pkg::ratio_stat_t            stat
);

  localparam int QB    = pslt_pkg::QUOT_BITS;
  localparam int CNT_W = $clog2(QB);

  logic [SUM_W-1:0] rr;
  logic [SUM_W-1:0] r;
  logic [SUM_W-1:0] d;
  logic [QB-1:0]    q;
  logic [QB-1:0]    scale;
  logic [CNT_W-1:0] bit_cnt;
  logic             phase_b;
  logic             first;
  logic             busy;
  logic             done;

  logic [SUM_W-1:0] diff_a;
  logic [SUM_W-1:0] diff_b;
  logic             ge_a;
  logic             ge_b;
  logic             last_step;

  // Doubling step and add-numerator step, both taken modulo den.
  always_comb begin
    diff_a    = d - rr;
    diff_b    = d - r;
    ge_a      = (rr >= diff_a);
    ge_b      = (rr >= diff_b);
    last_step = phase_b || !scale[QB-1];
  end

  // Iteration over the scale bits, most significant first.
  // The done pulse is low while busy and rises only as busy falls.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      phase_b <= 1'b0;
      first   <= 1'b0;
      bit_cnt <= '0;
    end else begin
      if (start) begin
        rr      <= '0;
        r       <= num;
        d       <= den;
        q       <= '0;
        scale   <= pslt_pkg::PERCENT_SCALE;
        bit_cnt <= CNT_W'(QB - 1);
        phase_b <= 1'b0;
        first   <= 1'b1;
        busy    <= 1'b1;
        done    <= 1'b0;
      end else if (busy) begin
        first <= 1'b0;
        if (first && (r >= d)) begin
          // A ratio of one or more reads as full scale.
          q    <= pslt_pkg::PERCENT_SCALE;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (!phase_b) begin
            q       <= {q[QB-2:0], ge_a};
            rr      <= ge_a ? (rr - diff_a) : (rr << 1);
            phase_b <= scale[QB-1];
          end else begin
            q       <= q + QB'(ge_b);
            rr      <= ge_b ? (rr - diff_b) : (rr + r);
            phase_b <= 1'b0;
          end
          if (last_step) begin
            scale <= scale << 1;
            if (bit_cnt == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              bit_cnt <= bit_cnt - CNT_W'(1);
            end
          end
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient  = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### hdl/packet_sequence_loss_tracker.sv
// ----------------------------------------------------------------------------
// Packet sequence loss tracker
// Counts received and lost packets per channel from header sequence numbers.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 65536-entry sequence memory, one entry per
// cycle, and accepts no transaction until the sweep is done. An account
// transaction then passes through the sequence memory read, the counter
// update, the sum and the serial ratio unit, which does one modular step per
// cycle over the bits of the percent scale, and then the hand-off to the
// output register; the next transaction is accepted only after that hand-off.
// A reset command, or a transaction on a channel beyond the configured
// count, goes straight to the hand-off. A finished result waits in the
// output register while the next transaction is worked on.
module packet_sequence_loss_tracker #(
  parameter int CHANNELS     = pslt_pkg::CHANNELS_DEFAULT,
  parameter int COUNTER_BITS = pslt_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  pslt_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_ready,
  output pslt_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W  = (COUNTER_BITS < 64) ? COUNTER_BITS + 1 : 64;
  localparam int PB     = pslt_pkg::PAIR_BITS;
  localparam int SB     = pslt_pkg::SEQ_BITS;
  localparam int QB     = pslt_pkg::QUOT_BITS;
  localparam int OB     = pslt_pkg::OUT_CNT_BITS;
  localparam int PAIRS  = 1 << PB;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  pslt_pkg::state_t state;
  pslt_pkg::state_t state_next;

  // Control and working registers.
  logic                    clearing;
  logic [PB-1:0]           clear_addr;
  pslt_pkg::item_t         cur;
  logic [IDX_W-1:0]        ch_idx;
  logic [SB:0]             seq_rdata;
  logic [7:0]              gap;
  logic [COUNTER_BITS-1:0] rec_new;
  logic [COUNTER_BITS-1:0] lost_new;
  pslt_pkg::result_t       res_pend;

  // Per-channel state.
  logic [COUNTER_BITS-1:0] rec_cnt  [CHANNELS];
  logic [COUNTER_BITS-1:0] lost_cnt [CHANNELS];
  logic [QB-1:0]           smooth   [CHANNELS];

  // Seen flag and last sequence per system/component pair.
  logic [SB:0] seq_mem [PAIRS];

  logic                    accept;
  logic                    ch_ok;
  logic [IDX_W-1:0]        acc_idx;
  logic                    mem_we;
  logic [PB-1:0]           mem_waddr;
  logic [SB:0]             mem_wdata;
  logic [7:0]              gap_c;
  logic [COUNTER_BITS-1:0] rec_cur;
  logic [COUNTER_BITS-1:0] rec_inc;
  logic [COUNTER_BITS:0]   lost_sum;
  logic [COUNTER_BITS-1:0] lost_add;
  logic [COUNTER_BITS:0]   sum_full;
  logic [SUM_W-1:0]        total;
  logic                    ratio_start;
  logic [QB-1:0]           ratio_q;
  pslt_pkg::ratio_stat_t   ratio_st;
  logic [QB:0]             sm_sum;
  logic [QB-1:0]           sm;
  logic                    out_free;

  // Handshake decode.
  assign accept   = item_valid && item_ready;
  assign ch_ok    = (32'(item.channel) < 32'(CHANNELS));
  assign acc_idx  = IDX_W'(item.channel);
  assign out_free = !result_valid || result_ready;

  // Sequencer: next state and strobes.
  always_comb begin
    state_next  = state;
    item_ready  = 1'b0;
    ratio_start = 1'b0;
    unique case (state)
      pslt_pkg::ST_IDLE: begin
        item_ready = !clearing;
        if (accept) begin
          if (!ch_ok || (item.command == pslt_pkg::CMD_RESET)) begin
            state_next = pslt_pkg::ST_FINISH;
          end else begin
            state_next = pslt_pkg::ST_READ;
          end
        end
      end
      pslt_pkg::ST_READ: begin
        state_next = pslt_pkg::ST_SUM;
      end
      pslt_pkg::ST_SUM: begin
        ratio_start = 1'b1;
        state_next  = pslt_pkg::ST_DIV;
      end
      pslt_pkg::ST_DIV: begin
        if (ratio_st.done) begin
          state_next = pslt_pkg::ST_FINISH;
        end
      end
      pslt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = pslt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pslt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pslt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep of the pair memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + PB'(1);
      if (clear_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pair memory port: the sweep writes zero, the update writes seen and seq.
  assign mem_we    = clearing || (state == pslt_pkg::ST_READ);
  assign mem_waddr = clearing ? clear_addr : {cur.system_id, cur.component_id};
  assign mem_wdata = clearing ? '0 : {1'b1, cur.sequence_req};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[mem_waddr] <= mem_wdata;
    end
    seq_rdata <= seq_mem[{item.system_id, item.component_id}];
  end

  // Gap and saturating counter arithmetic for the current channel.
  always_comb begin
    gap_c    = seq_rdata[SB] ? (cur.sequence_req - seq_rdata[SB-1:0] - 8'd1) : 8'd0;
    rec_cur  = rec_cnt[ch_idx];
    rec_inc  = (rec_cur == CNT_MAX) ? rec_cur : rec_cur + COUNTER_BITS'(1);
    lost_sum = {1'b0, lost_cnt[ch_idx]} + (COUNTER_BITS + 1)'(gap_c);
    lost_add = lost_sum[COUNTER_BITS] ? CNT_MAX : lost_sum[COUNTER_BITS-1:0];
  end

  // Divisor: received plus lost, clamped to the divider width.
  always_comb begin
    sum_full = {1'b0, rec_new} + {1'b0, lost_new};
    if ((SUM_W <= COUNTER_BITS) && sum_full[COUNTER_BITS]) begin
      total = '1;
    end else begin
      total = sum_full[SUM_W-1:0];
    end
  end

  // Smoothing: mean of the new figure and the previous one.
  always_comb begin
    sm_sum = {1'b0, ratio_q} + {1'b0, smooth[ch_idx]};
    sm     = sm_sum[QB:1];
  end

  pslt_ratio #(
    .SUM_W(SUM_W)
  ) u_ratio (
    .clk      (clk),
    .rst      (rst),
    .start    (ratio_start),
    .num      (SUM_W'(lost_new)),
    .den      (total),
    .quotient (ratio_q),
    .stat     (ratio_st)
  );

  // Per-channel counters and smoothed loss.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rec_cnt[i]  <= '0;
        lost_cnt[i] <= '0;
        smooth[i]   <= '0;
      end
    end else begin
      if (accept && ch_ok && (item.command == pslt_pkg::CMD_RESET)) begin
        rec_cnt[acc_idx]  <= '0;
        lost_cnt[acc_idx] <= '0;
        smooth[acc_idx]   <= '0;
      end
      if (state == pslt_pkg::ST_READ) begin
        rec_cnt[ch_idx]  <= rec_inc;
        lost_cnt[ch_idx] <= lost_add;
      end
      if ((state == pslt_pkg::ST_DIV) && ratio_st.done) begin
        smooth[ch_idx] <= sm;
      end
    end
  end

  // Transaction capture, working values and pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= item;
      ch_idx   <= acc_idx;
      res_pend <= '0;
    end
    if (state == pslt_pkg::ST_READ) begin
      gap      <= gap_c;
      rec_new  <= rec_inc;
      lost_new <= lost_add;
    end
    if ((state == pslt_pkg::ST_DIV) && ratio_st.done) begin
      res_pend.lost_in_gap     <= gap;
      res_pend.received_total  <= (|(rec_new >> OB)) ? '1 : OB'(rec_new);
      res_pend.lost_total      <= (|(lost_new >> OB)) ? '1 : OB'(lost_new);
      res_pend.loss_percent_q8 <= sm;
      res_pend.report_due      <= (rec_new[pslt_pkg::REPORT_BITS-1:0] == '0);
    end
  end

  // Output register: a new result takes priority over clearing the old one.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == pslt_pkg::ST_FINISH) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pslt_pkg::ST_FINISH) && out_free) begin
      result <= res_pend;
    end
  end

`ifndef SYNTH
  // No transaction is taken while the pair memory is being swept.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item_ready)
    else $error("transaction accepted during memory sweep");

  // One transaction at a time: acceptance closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item_ready)
    else $error("input reopened right after acceptance");

  // The ratio unit reports completion only while the sequencer waits for it.
  a_ratio_done_in_div: assert property (@(posedge clk) disable iff (rst)
    ratio_st.done |-> (state == pslt_pkg::ST_DIV))
    else $error("ratio completion outside the divide state");

  // The smoothed loss never exceeds full scale.
  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.loss_percent_q8 <= pslt_pkg::PERCENT_SCALE))
    else $error("loss percent above full scale");
`endif

endmodule
